@@ hdl/rsxy_pkg.sv @@
`timescale 1ns / 1ps

package rsxy_pkg;

  typedef struct packed {
    logic [15:0] x_origin;
    logic [15:0] y_origin;
    logic [15:0] rect_length;
    logic [15:0] rect_height;
    logic        last_entry;
  } in_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_length;
    logic [15:0] out_height;
    logic        out_last;
    logic        overflowed;
  } out_t;

  // one stored record, as held in the record memory
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] len;
    logic [15:0] hgt;
  } rec_t;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_RDI   = 7'b0000010,
    S_LDI   = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_WBI   = 7'b0010000,
    S_ELD   = 7'b0100000,
    S_EWAIT = 7'b1000000
  } state_t;

endpackage

@@ hdl/rsxy_ram.sv @@
`timescale 1ns / 1ps

module rsxy_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/record_sort_by_xy_key_core.sv @@
`timescale 1ns / 1ps

// record sorter: collects rectangle records, sorts them by (x, y) and streams them out
// in channel (in_valid/in_ready/in_data): one record per transaction; last_entry closes
//   the set. records arriving while the store holds MAX_ENTRIES are dropped and the
//   overflowed flag is raised on every result of that set.
// out channel (out_valid/out_ready/out_data): one transaction per stored record, in
//   ascending order of x then y, out_last on the final one.
// in_ready is high only while collecting; one record is taken per cycle then.
// after the closing record, the exchange sort of n records runs on a single 32-bit key
//   comparator over the record memory (one read, one write port).
// emission passes each record through a load state and a wait state; a stalled receiver
//   simply holds the output register and the sequencer waits.
// the block takes no new record until the last result of the set has gone.
// reset (rst_n low, synchronous) empties the store and clears the overflow flag; the
//   memory contents need no clearing since only entries of the current set are read.

module record_sort_by_xy_key_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsxy_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsxy_pkg::out_t out_data
);

  import rsxy_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int REC_W = $bits(rec_t);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  rec_t             cur_r, cur_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata_raw;
  rec_t             ram_rdata;

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             swap;
  rec_t             in_rec;

  assign ram_rdata = rec_t'(ram_rdata_raw);
  assign cnt_m1    = count_r - CNT_W'(1);
  assign last_idx  = cnt_m1[IDX_W-1:0];
  assign full      = (count_r == CNT_W'(MAX_ENTRIES));
  // entry i lives in cur_r during its pass, so k == i never swaps
  assign swap      = (k_r != i_r) && ({ram_rdata.x, ram_rdata.y} > {cur_r.x, cur_r.y});
  assign in_rec    = '{x: in_data.x_origin, y: in_data.y_origin,
                       len: in_data.rect_length, hgt: in_data.rect_height};

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = in_rec;
    ram_raddr     = i_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (!full) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_entry) begin
            i_nxt     = '0;
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: begin
        ram_raddr = i_r;
        state_nxt = S_LDI;
      end
      S_LDI: begin
        cur_nxt   = ram_rdata;
        ram_raddr = '0;
        k_nxt     = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ram_raddr = k_r + IDX_W'(1);
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = k_r;
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        if (k_r == last_idx) begin
          state_nxt = S_WBI;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_WBI: begin
        // write back entry i while fetching the next one
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = cur_r;
        if (i_r == last_idx) begin
          ram_raddr = '0;
          j_nxt     = '0;
          state_nxt = S_ELD;
        end else begin
          ram_raddr = i_r + IDX_W'(1);
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_LDI;
        end
      end
      S_ELD: begin
        ram_raddr     = j_r;
        out_nxt       = '{out_x: ram_rdata.x, out_y: ram_rdata.y,
                          out_length: ram_rdata.len, out_height: ram_rdata.hgt,
                          out_last: (j_r == last_idx), overflowed: ovf_r};
        out_valid_nxt = 1'b1;
        state_nxt     = S_EWAIT;
      end
      S_EWAIT: begin
        ram_raddr = j_r + IDX_W'(1);
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.out_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_ELD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  rsxy_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("record count beyond capacity");

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EWAIT))
    else $error("result shown outside the emission wait state");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.out_last) |=> (count_r == '0 && !ovf_r && in_ready))
    else $error("set not cleared after final result");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (k_r <= last_idx && i_r <= last_idx))
    else $error("sort index past stored records");
`endif

endmodule
